// ===== rtl/core/csma_ca_backoff_engine_macros.svh =====
// ----------------------------------------------------------------------------
// csma_ca_backoff_engine assertion macros
// Shorthand for clocked implication checks with async active-low reset.
// ----------------------------------------------------------------------------
`ifndef CSMA_CA_BACKOFF_ENGINE_MACROS_SVH
`define CSMA_CA_BACKOFF_ENGINE_MACROS_SVH

// same-cycle implication
`define CBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbe: check failed");

// next-cycle implication
`define CBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbe: check failed");

`endif

// ===== rtl/core/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg
// Types and codes shared by the CSMA/CA backoff engine files.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int unsigned CW_BITS   = 10;
  localparam int unsigned RUN_BITS  = 4;
  localparam int unsigned IDX_BITS  = 2;

  // commands
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_OUTCOME = 2'd2;

  // result events
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_TX      = 3'd1;
  localparam logic [2:0] EV_DELIVER = 3'd2;
  localparam logic [2:0] EV_DROP    = 3'd3;
  localparam logic [2:0] EV_RETRY   = 3'd4;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_CW_MIN = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_CW_MAX = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_DIFS   = 2'd2;

  // register reset values
  localparam logic [CW_BITS-1:0]  CW_MIN_RST = 10'd15;
  localparam logic [CW_BITS-1:0]  CW_MAX_RST = 10'd255;
  localparam logic [RUN_BITS-1:0] DIFS_RST   = 4'd2;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_DIFS    = 2'd1,
    PH_BACKOFF = 2'd2,
    PH_WAIT    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0]         command;
    logic               channel_idle;
    logic [CW_BITS-1:0] random_draw;
    logic               outcome_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [CW_BITS-1:0] contention_window;
    logic [CW_BITS-1:0] backoff_left;
    logic               engaged;
  } res_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] index;
    logic [CW_BITS-1:0]  value;
  } cfg_t;

endpackage

// ===== rtl/core/cbe_if.sv =====
// ----------------------------------------------------------------------------
// cbe_if
// Valid/ready channels of the backoff engine: request, result, config write.
// ----------------------------------------------------------------------------
interface cbe_req_if;
  import cbe_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbe_res_if;
  import cbe_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbe_cfg_if;
  import cbe_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/csma_ca_backoff_engine.sv =====
// ----------------------------------------------------------------------------
// csma_ca_backoff_engine
// Transmit-side CSMA/CA binary exponential backoff for one packet at a time.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        one item is
//  req_i    in   command, channel_idle, random_draw, outcome_ok a command
//  res_o    out  event_res, contention_window, backoff_left,    state after it
//                engaged
//  cfg_i    in   index, value                                   a register write
//
//  One item per cycle: each request updates the phase and counters, and its
//  result lands in the output register on the next edge.
//  The output register sets the rate: a request is taken whenever that
//  register is empty or being drained in the same cycle.
//  Reset: phase idle, counters and window zero, registers at their defaults.
//  cfg_i is always ready.
// ----------------------------------------------------------------------------
module csma_ca_backoff_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  cbe_req_if.sink           req_i,
  cbe_res_if.source         res_o,
  cbe_cfg_if.sink           cfg_i
);
  import cbe_pkg::*;

  logic [CW_BITS-1:0]  cw_min_q, cw_max_q;
  logic [RUN_BITS-1:0] difs_q;

  phase_e              phase_q, phase_d;
  logic [RUN_BITS-1:0] run_q, run_d;
  logic [CW_BITS-1:0]  bo_q, bo_d;
  logic [CW_BITS-1:0]  win_q, win_d;
  logic [2:0]          ev;

  logic                res_valid_q;
  res_t                res_data_q;

  logic                req_acc;
  logic [RUN_BITS-1:0] need;
  logic [RUN_BITS-1:0] run_inc;
  logic [CW_BITS-1:0]  bo_draw;
  logic [CW_BITS-1:0]  bo_dec;
  logic [CW_BITS:0]    grown;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_min_q <= CW_MIN_RST;
      cw_max_q <= CW_MAX_RST;
      difs_q   <= DIFS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_CW_MIN: cw_min_q <= cfg_i.data.value;
        REG_CW_MAX: cw_max_q <= cfg_i.data.value;
        REG_DIFS:   difs_q   <= cfg_i.data.value[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign need    = (difs_q == '0) ? RUN_BITS'(1) : difs_q;
  assign run_inc = run_q + RUN_BITS'(1);
  assign bo_draw = req_i.data.random_draw & win_q;
  assign bo_dec  = (req_i.data.channel_idle && bo_q != '0) ? bo_q - CW_BITS'(1) : bo_q;
  assign grown   = {win_q, 1'b1};

  always_comb begin
    phase_d = phase_q;
    run_d   = run_q;
    bo_d    = bo_q;
    win_d   = win_q;
    ev      = EV_NONE;
    case (req_i.data.command)
      CMD_START: begin
        win_d   = cw_min_q;
        run_d   = '0;
        bo_d    = '0;
        phase_d = PH_DIFS;
      end
      CMD_TICK: begin
        case (phase_q)
          PH_DIFS: begin
            if (!req_i.data.channel_idle) begin
              run_d = '0;
            // counter wrap also ends DIFS
            end else if (run_inc == '0 || run_inc >= need) begin
              run_d = '0;
              bo_d  = bo_draw;
              if (bo_draw == '0) begin
                ev      = EV_TX;
                phase_d = PH_WAIT;
              end else begin
                phase_d = PH_BACKOFF;
              end
            end else begin
              run_d = run_inc;
            end
          end
          PH_BACKOFF: begin
            bo_d = bo_dec;
            if (bo_dec == '0) begin
              ev      = EV_TX;
              phase_d = PH_WAIT;
            end
          end
          default: ;
        endcase
      end
      CMD_OUTCOME: begin
        if (phase_q == PH_WAIT) begin
          if (req_i.data.outcome_ok) begin
            ev      = EV_DELIVER;
            phase_d = PH_IDLE;
          end else if (win_q == cw_max_q) begin
            ev      = EV_DROP;
            phase_d = PH_IDLE;
          end else begin
            win_d   = (grown >= {1'b0, cw_max_q}) ? cw_max_q : grown[CW_BITS-1:0];
            run_d   = '0;
            bo_d    = '0;
            ev      = EV_RETRY;
            phase_d = PH_DIFS;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      run_q   <= '0;
      bo_q    <= '0;
      win_q   <= '0;
    end else if (req_acc) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      bo_q    <= bo_d;
      win_q   <= win_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (req_acc) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      res_data_q.event_res         <= ev;
      res_data_q.contention_window <= win_d;
      res_data_q.backoff_left      <= bo_d;
      res_data_q.engaged           <= (phase_d != PH_IDLE);
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_data_q;

endmodule

// ===== rtl/core/cbe_checker.sv =====
// ----------------------------------------------------------------------------
// cbe_checker
// Port-level checks on the backoff engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "csma_ca_backoff_engine_macros.svh"

module cbe_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input cbe_pkg::req_t req_data_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input cbe_pkg::res_t res_data_i
);
  import cbe_pkg::*;

  logic req_acc;
  logic res_stall;
  logic start_acc;
  logic quiet_res;
  logic tx_res;
  logic end_res;
  logic no_bo;

  assign req_acc   = req_valid_i && req_ready_i;
  assign res_stall = res_valid_i && !res_ready_i;
  assign start_acc = req_acc && req_data_i.command == CMD_START;
  assign no_bo     = res_data_i.backoff_left == '0;
  assign quiet_res = res_data_i.event_res == EV_NONE && no_bo;
  assign tx_res    = res_valid_i && res_data_i.event_res == EV_TX;
  assign end_res   = res_valid_i &&
                     (res_data_i.event_res == EV_DELIVER || res_data_i.event_res == EV_DROP);

  `CBE_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_stall, res_valid_i && $stable(res_data_i))

  `CBE_ASSERT_NEXT(a_acc_gives_res, clk_i, rst_ni, req_acc, res_valid_i)

  // a start always yields an engaged, quiet result with no backoff yet
  `CBE_ASSERT_NEXT(a_start_res, clk_i, rst_ni, start_acc, res_data_i.engaged && quiet_res)

  `CBE_ASSERT_NOW(a_tx_state, clk_i, rst_ni, tx_res, res_data_i.engaged && no_bo)

  `CBE_ASSERT_NOW(a_end_state, clk_i, rst_ni, end_res, !res_data_i.engaged && no_bo)

endmodule

bind csma_ca_backoff_engine cbe_checker u_cbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_data_i  (req_i.data),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

// ===== tb/csma_ca_backoff_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csma_ca_backoff_engine_checker
// Follows accepted commands and register writes, keeps its own copy of the
// engine's phase, idle run, backoff count and window, and checks each result
// item field by field against the oldest predicted item.
// ----------------------------------------------------------------------------
module csma_ca_backoff_engine_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  cbe_req_if              req_i,
  cbe_res_if              res_i,
  cbe_cfg_if              cfg_i,
  output int unsigned     mismatches_o,
  output int unsigned     pending_o,
  output cbe_pkg::phase_e phase_o
);
  import cbe_pkg::*;

  logic [CW_BITS-1:0]  cw_min_q;
  logic [CW_BITS-1:0]  cw_max_q;
  logic [RUN_BITS-1:0] difs_q;
  logic [CW_BITS-1:0]  window_q;
  logic [CW_BITS-1:0]  backoff_q;
  logic [RUN_BITS-1:0] idle_run_q;
  phase_e              phase_q;
  res_t                predicted_q[$];

  task automatic flag_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  task automatic compare_result(input res_t want, input res_t got);
    if (got.event_res !== want.event_res)
      flag_mismatch($sformatf("event_res %0d, expected %0d", got.event_res, want.event_res));
    if (got.contention_window !== want.contention_window)
      flag_mismatch($sformatf("contention_window %0d, expected %0d",
                              got.contention_window, want.contention_window));
    if (got.backoff_left !== want.backoff_left)
      flag_mismatch($sformatf("backoff_left %0d, expected %0d",
                              got.backoff_left, want.backoff_left));
    if (got.engaged !== want.engaged)
      flag_mismatch($sformatf("engaged %0b, expected %0b", got.engaged, want.engaged));
  endtask

  // Applies one command to the tracked state and returns the state seen after it.
  function automatic res_t advance_engine(input req_t cmd_item);
    res_t                after;
    logic [2:0]          ev;
    logic [RUN_BITS-1:0] need;
    logic [CW_BITS:0]    grown;
    ev   = EV_NONE;
    need = (difs_q == '0) ? RUN_BITS'(1) : difs_q;
    case (cmd_item.command)
      CMD_START: begin
        window_q   = cw_min_q;
        idle_run_q = '0;
        backoff_q  = '0;
        phase_q    = PH_DIFS;
      end
      CMD_TICK: begin
        if (phase_q == PH_DIFS) begin
          if (cmd_item.channel_idle) begin
            idle_run_q = idle_run_q + 1'b1;
            if (idle_run_q == '0 || idle_run_q >= need) begin
              idle_run_q = '0;
              backoff_q  = cmd_item.random_draw & window_q;
              if (backoff_q == '0) begin
                ev      = EV_TX;
                phase_q = PH_WAIT;
              end else begin
                phase_q = PH_BACKOFF;
              end
            end
          end else begin
            idle_run_q = '0;
          end
        end else if (phase_q == PH_BACKOFF) begin
          // busy ticks freeze the count, DIFS is not repeated
          if (cmd_item.channel_idle && backoff_q != '0) backoff_q = backoff_q - 1'b1;
          if (backoff_q == '0) begin
            ev      = EV_TX;
            phase_q = PH_WAIT;
          end
        end
      end
      CMD_OUTCOME: begin
        if (phase_q == PH_WAIT) begin
          if (cmd_item.outcome_ok) begin
            ev      = EV_DELIVER;
            phase_q = PH_IDLE;
          end else if (window_q == cw_max_q) begin
            ev      = EV_DROP;
            phase_q = PH_IDLE;
          end else begin
            grown      = {window_q, 1'b1};
            window_q   = (grown >= {1'b0, cw_max_q}) ? cw_max_q : grown[CW_BITS-1:0];
            idle_run_q = '0;
            backoff_q  = '0;
            ev         = EV_RETRY;
            phase_q    = PH_DIFS;
          end
        end
      end
      default: ;
    endcase
    after.event_res         = ev;
    after.contention_window = window_q;
    after.backoff_left      = backoff_q;
    after.engaged           = (phase_q != PH_IDLE);
    return after;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_min_q     = CW_MIN_RST;
      cw_max_q     = CW_MAX_RST;
      difs_q       = DIFS_RST;
      window_q     = '0;
      backoff_q    = '0;
      idle_run_q   = '0;
      phase_q      = PH_IDLE;
      mismatches_o = 0;
      predicted_q.delete();
      pending_o <= 0;
      phase_o   <= PH_IDLE;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.index)
          REG_CW_MIN: cw_min_q = cfg_i.data.value;
          REG_CW_MAX: cw_max_q = cfg_i.data.value;
          REG_DIFS:   difs_q   = cfg_i.data.value[RUN_BITS-1:0];
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (predicted_q.size() == 0) flag_mismatch("result item with nothing predicted");
        else compare_result(predicted_q.pop_front(), res_i.data);
      end
      if (req_i.valid && req_i.ready) predicted_q.push_back(advance_engine(req_i.data));
      pending_o <= predicted_q.size();
      phase_o   <= phase_q;
    end
  end

endmodule

// ===== tb/csma_ca_backoff_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csma_ca_backoff_engine_tb
// Drives directed and random command streams through the backoff engine
// under several window and DIFS settings, with random stalls on both
// channels; the checker beside the engine predicts and compares results.
// ----------------------------------------------------------------------------
module csma_ca_backoff_engine_tb;
  import cbe_pkg::*;

  localparam logic [1:0]          CMD_RESERVED = 2'd3;
  localparam logic [IDX_BITS-1:0] REG_UNUSED   = 2'd3;
  localparam int                  LONG_HOLD    = 48;
  localparam int                  RUN_LIMIT_NS = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  bit          steady;
  bit          long_hold_arm;
  int unsigned mismatches;
  int unsigned pending;
  phase_e      engine_phase;

  cbe_req_if req_if ();
  cbe_res_if res_if ();
  cbe_cfg_if cfg_if ();

  csma_ca_backoff_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  csma_ca_backoff_engine_checker engine_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .phase_o      (engine_phase)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // Result side: random stalls, one long hold-off, none in the last phase.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_arm && !held) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(0, 11)) @(posedge clk_i);
      end
    end
  end

  // Holds the item until taken; valid stays high unless a gap follows.
  task automatic offer(input req_t item);
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
    if (!steady && $urandom_range(0, 9) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CW_BITS-1:0] val);
    cfg_t wr;
    wr.index = idx;
    wr.value = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= wr;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic reconfigure(input logic [CW_BITS-1:0] cw_min, input logic [CW_BITS-1:0] cw_max,
                             input logic [CW_BITS-1:0] difs_raw);
    settle();
    write_reg(REG_UNUSED, CW_BITS'($urandom_range(0, 1023)));
    write_reg(REG_CW_MIN, cw_min);
    write_reg(REG_CW_MAX, cw_max);
    write_reg(REG_DIFS, difs_raw);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly well-formed packet flow steered by the predicted phase, which
  // may lag by one item; a stray tick or outcome is simply ignored.
  function automatic req_t pick_command(input phase_e ph);
    req_t        item;
    int unsigned roll;
    roll              = $urandom_range(0, 99);
    item.channel_idle = ($urandom_range(0, 4) != 0);
    item.random_draw  = $urandom_range(0, 1) ? CW_BITS'($urandom_range(0, 1023))
                                             : CW_BITS'($urandom_range(0, 15));
    item.outcome_ok   = 1'($urandom_range(0, 1));
    case (ph)
      PH_IDLE: item.command = (roll < 85) ? CMD_START : (roll < 90) ? CMD_TICK :
                              (roll < 95) ? CMD_OUTCOME : CMD_RESERVED;
      PH_WAIT: item.command = (roll < 85) ? CMD_OUTCOME : (roll < 93) ? CMD_TICK :
                              (roll < 97) ? CMD_START : CMD_RESERVED;
      default: item.command = (roll < 92) ? CMD_TICK : (roll < 95) ? CMD_START :
                              (roll < 98) ? CMD_OUTCOME : CMD_RESERVED;
    endcase
    return item;
  endfunction

  task automatic run_traffic(input int unsigned count);
    repeat (count) offer(pick_command(engine_phase));
  endtask

  initial begin : stimulus
    req_if.valid  <= 1'b0;
    req_if.data   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    rst_ni        <= 1'b0;
    steady        = 1'b0;
    long_hold_arm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: ignored commands, DIFS restart on busy, zero backoff,
    // retry growth, frozen backoff, restart while engaged
    offer('{CMD_TICK,     1'b1, 10'h3FF, 1'b1});
    offer('{CMD_OUTCOME,  1'b1, 10'h3FF, 1'b1});
    offer('{CMD_RESERVED, 1'b1, 10'h3FF, 1'b1});
    offer('{CMD_START,    1'b0, 10'h000, 1'b0});
    offer('{CMD_TICK,     1'b0, 10'h3FF, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h3FF, 1'b0});
    offer('{CMD_TICK,     1'b0, 10'h3FF, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h3FF, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h3F0, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h3FF, 1'b1});
    offer('{CMD_OUTCOME,  1'b1, 10'h000, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h000, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h3FF, 1'b0});
    offer('{CMD_TICK,     1'b0, 10'h000, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h000, 1'b0});
    offer('{CMD_START,    1'b1, 10'h3FF, 1'b1});

    // full window, DIFS register written as zero: largest backoff, drop at cw_max
    reconfigure(10'd1023, 10'd1023, 10'h3F0);
    offer('{CMD_START,    1'b1, 10'h000, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h3FF, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h000, 1'b0});
    offer('{CMD_START,    1'b0, 10'h000, 1'b1});
    offer('{CMD_TICK,     1'b1, 10'h000, 1'b1});
    offer('{CMD_OUTCOME,  1'b0, 10'h3FF, 1'b0});
    offer('{CMD_START,    1'b0, 10'h3FF, 1'b0});
    offer('{CMD_TICK,     1'b1, 10'h000, 1'b0});
    offer('{CMD_OUTCOME,  1'b0, 10'h000, 1'b1});

    reconfigure(10'd1, 10'd1023, 10'd1);
    run_traffic(100);
    reconfigure(10'd63, 10'd7, 10'd3);  // cw_min above cw_max
    long_hold_arm = 1'b1;
    run_traffic(100);
    reconfigure(10'd3, 10'd31, 10'd15);
    run_traffic(100);
    reconfigure(10'd0, 10'd1, 10'd1);
    run_traffic(100);
    reconfigure(10'd1, 10'd0, 10'd4);
    run_traffic(100);
    reconfigure(10'd7, 10'd63, 10'd2);
    run_traffic(100);
    reconfigure(CW_MIN_RST, CW_MAX_RST, 10'(DIFS_RST));
    run_traffic(100);
    for (int p = 0; p < 5; p++) begin
      reconfigure(CW_BITS'((1 << $urandom_range(0, 5)) - 1),
                  CW_BITS'((1 << $urandom_range(1, 7)) - 1),
                  CW_BITS'($urandom_range(0, 1023)));
      steady = (p == 4);
      run_traffic(105);
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
